// ===== rtl/bsa_pkg.sv =====
`timescale 1ns / 1ps
package bsa_pkg;

    // Request codes
    localparam logic [1:0] REQ_WRLEN = 2'd0;
    localparam logic [1:0] REQ_ACC   = 2'd1;
    localparam logic [1:0] REQ_READ  = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] CFG_NUM_DOCS = 2'd0;
    localparam logic [1:0] CFG_AVG_LEN  = 2'd1;
    localparam logic [1:0] CFG_K1       = 2'd2;
    localparam logic [1:0] CFG_B        = 2'd3;

    // Log unit sizes
    localparam int LOG_IN_W   = 14;
    localparam int LOG_E_W    = 4;
    localparam int LOG_FRAC_W = 20;
    localparam int LOG_OUT_W  = LOG_E_W + LOG_FRAC_W;
    localparam int MANT_W     = 31;

    // Divider sizes
    localparam int DIV_NUM_W = 61;
    localparam int DIV_DEN_W = 54;

    // Datapath sizes
    localparam int IDF_W  = 20;
    localparam int WGT_W  = 21;
    localparam int CMAG_W = 26;
    localparam int NORM_W = 37;

    localparam logic [29:0] LN2_Q30 = 30'd744261118;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [11:0] doc_id;
        logic [15:0] term_freq;
        logic [12:0] doc_freq;
        logic [15:0] doc_len;
    } bsa_req_t;

    typedef struct packed {
        logic [11:0]        doc_id_out;
        logic signed [31:0] score;
    } bsa_res_t;

    typedef struct packed {
        logic busy;
        logic done;
    } bsa_unit_sts_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RD_WAIT,
        ST_LOGN,
        ST_LOGD,
        ST_IDF,
        ST_LMUL,
        ST_LDIV,
        ST_KMUL0,
        ST_KMUL1,
        ST_WDIV,
        ST_CMUL,
        ST_UPD
    } bsa_state_t;

endpackage

// ===== rtl/bsa_ram.sv =====
`timescale 1ns / 1ps
module bsa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== rtl/bsa_log2.sv =====
`timescale 1ns / 1ps
module bsa_log2 (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [bsa_pkg::LOG_IN_W-1:0]   x,
    output bsa_pkg::bsa_unit_sts_t         sts,
    output logic [bsa_pkg::LOG_OUT_W-1:0]  result
);
    import bsa_pkg::*;

    logic                    busy_reg;
    logic                    done_reg;
    logic [4:0]              cnt_reg;
    logic [MANT_W-1:0]       m_reg;
    logic [MANT_W-1:0]       m_next;
    logic [LOG_FRAC_W-1:0]   frac_reg;
    logic [LOG_E_W-1:0]      e_reg;
    logic [LOG_E_W-1:0]      e_calc;
    logic [LOG_IN_W-1:0]     x_eff;
    logic [MANT_W-1:0]       m_init;
    logic [2*MANT_W-1:0]     sq;
    logic [MANT_W:0]         sq_hi;
    logic                    frac_bit;

    // Find the leading one and normalize to Q1.30
    always_comb
    begin
        x_eff  = (x == '0) ? LOG_IN_W'(1) : x;
        e_calc = '0;
        for (int i = 0; i < LOG_IN_W; i++)
        begin
            if (x_eff[i])
            begin
                e_calc = LOG_E_W'(i);
            end
        end
        m_init = MANT_W'({x_eff, 30'b0} >> e_calc);
    end

    // Square the mantissa, halve when it reaches two
    always_comb
    begin
        sq       = m_reg * m_reg;
        sq_hi    = sq[2*MANT_W-1:30];
        frac_bit = sq_hi[MANT_W];
        m_next   = frac_bit ? sq_hi[MANT_W:1] : sq_hi[MANT_W-1:0];
    end

    // Control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start && !busy_reg)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 5'(LOG_FRAC_W - 1);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 5'd1;
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        if (start && !busy_reg)
        begin
            m_reg    <= m_init;
            e_reg    <= e_calc;
            frac_reg <= '0;
        end
        else if (busy_reg)
        begin
            m_reg             <= m_next;
            frac_reg[cnt_reg] <= frac_bit;
        end
    end

    assign sts.busy = busy_reg;
    assign sts.done = done_reg;
    assign result   = {e_reg, frac_reg};

endmodule

// ===== rtl/bsa_div.sv =====
`timescale 1ns / 1ps
module bsa_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [bsa_pkg::DIV_NUM_W-1:0] num,
    input  logic [bsa_pkg::DIV_DEN_W-1:0] den,
    output bsa_pkg::bsa_unit_sts_t        sts,
    output logic [bsa_pkg::DIV_NUM_W-1:0] quot
);
    import bsa_pkg::*;

    localparam int CNT_W = $clog2(DIV_NUM_W);

    logic                 busy_reg;
    logic                 done_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic [DIV_DEN_W-1:0] rem_reg;
    logic [DIV_DEN_W-1:0] den_reg;
    logic [DIV_NUM_W-1:0] num_reg;
    logic [DIV_NUM_W-1:0] q_reg;
    logic [DIV_DEN_W:0]   trial;
    logic [DIV_DEN_W:0]   diff;
    logic                 q_bit;

    // One restoring step
    always_comb
    begin
        trial = {rem_reg, num_reg[DIV_NUM_W-1]};
        diff  = trial - {1'b0, den_reg};
        q_bit = (trial >= {1'b0, den_reg});
    end

    // Control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start && !busy_reg)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(DIV_NUM_W - 1);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        if (start && !busy_reg)
        begin
            rem_reg <= '0;
            den_reg <= den;
            num_reg <= num;
            q_reg   <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg <= q_bit ? diff[DIV_DEN_W-1:0] : trial[DIV_DEN_W-1:0];
            num_reg <= {num_reg[DIV_NUM_W-2:0], 1'b0};
            q_reg   <= {q_reg[DIV_NUM_W-2:0], q_bit};
        end
    end

    assign sts.busy = busy_reg;
    assign sts.done = done_reg;
    assign quot     = q_reg;

endmodule

// ===== rtl/bm25_score_accumulator_unit.sv =====
`timescale 1ns / 1ps
// BM25 score accumulator. Raise start with a request word while busy is low.
// A length write is done in the idle state; a read-and-clear passes the read
// wait state, and its result appears on result for exactly one cycle, marked
// by result_valid, and must be taken then since the block cannot be stalled.
// An accumulate runs two 61-step passes of the bit-serial divider, the second
// skipped for a zero divisor, and two 20-step passes of the log2 squaring
// unit. After reset every score memory entry is swept to zero with busy high;
// configuration writes are taken at any time. MAX_DOCS must be a power of two.
module bm25_score_accumulator_unit #(
    parameter int MAX_DOCS = 4096
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  bsa_pkg::bsa_req_t req,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [1:0]        cfg_index,
    input  logic [23:0]       cfg_data,
    output logic              result_valid,
    output bsa_pkg::bsa_res_t result
);
    import bsa_pkg::*;

    localparam int AW = $clog2(MAX_DOCS);

    bsa_state_t state_reg, state_next;

    logic [12:0] num_docs_reg;
    logic [23:0] avg_len_reg;
    logic [15:0] k1_reg;
    logic [12:0] b_reg;

    bsa_req_t              req_reg;
    logic [AW-1:0]         clr_cnt_reg;
    logic [LOG_OUT_W-1:0]  ln_reg;
    logic [LOG_OUT_W-1:0]  dmag_reg;
    logic                  neg_reg;
    logic [IDF_W-1:0]      idf_reg;
    logic [NORM_W-1:0]     blen_reg;
    logic [NORM_W-1:0]     norm_reg;
    logic [34:0]           kprod_lo_reg;
    logic [32:0]           wnum_reg;
    logic [DIV_DEN_W-1:0]  den_reg;
    logic [WGT_W-1:0]      w_reg;
    logic [CMAG_W-1:0]     cmag_reg;
    bsa_res_t              result_reg;
    logic                  result_valid_reg;

    logic                  accept;
    logic [AW-1:0]         in_idx;
    logic [AW-1:0]         idx;
    logic [12:0]           b_eff;
    logic [23:0]           avg_eff;
    logic [LOG_IN_W-1:0]   numr;
    logic [LOG_IN_W-1:0]   denr;

    logic                  log_start;
    logic [LOG_IN_W-1:0]   log_x;
    bsa_unit_sts_t         log_sts;
    logic [LOG_OUT_W-1:0]  log_res;
    logic                  div_start;
    logic [DIV_NUM_W-1:0]  div_num;
    logic [DIV_DEN_W-1:0]  div_den;
    bsa_unit_sts_t         div_sts;
    logic [DIV_NUM_W-1:0]  div_quot;

    logic                  score_we;
    logic [AW-1:0]         score_waddr;
    logic [31:0]           score_wdata;
    logic                  score_re;
    logic [31:0]           score_rdata;
    logic                  len_we;
    logic                  len_re;
    logic [15:0]           len_rdata;

    logic [54:0]           idf_prod;
    logic [41:0]           cmag_prod;
    logic [53:0]           khi_prod;
    logic [33:0]           s_sum;
    logic [31:0]           s_sat;

    assign accept    = start && !busy;
    assign in_idx    = AW'(req.doc_id);
    assign idx       = AW'(req_reg.doc_id);
    assign cfg_ready = 1'b1;

    // Effective parameters and log arguments
    always_comb
    begin
        b_eff   = (b_reg > 13'd4096) ? 13'd4096 : b_reg;
        avg_eff = (avg_len_reg == '0) ? 24'd1 : avg_len_reg;
        if (req_reg.doc_freq > num_docs_reg)
        begin
            numr = LOG_IN_W'(1);
        end
        else
        begin
            numr = {num_docs_reg, 1'b0} - {req_reg.doc_freq, 1'b0} + LOG_IN_W'(1);
        end
        denr = {req_reg.doc_freq, 1'b1};
    end

    // Arithmetic between sequencer steps
    always_comb
    begin
        idf_prod  = 55'(dmag_reg) * 55'(LN2_Q30) + (55'd1 << 33);
        cmag_prod = 42'(idf_reg) * 42'(w_reg) + (42'd1 << 15);
        khi_prod  = (54'(k1_reg) * 54'(norm_reg[NORM_W-1:19])) << 19;
        if (neg_reg)
        begin
            s_sum = {{2{score_rdata[31]}}, score_rdata} - 34'(cmag_reg);
        end
        else
        begin
            s_sum = {{2{score_rdata[31]}}, score_rdata} + 34'(cmag_reg);
        end
        if (s_sum[33] != s_sum[31])
        begin
            s_sat = s_sum[33] ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end
        else
        begin
            s_sat = s_sum[31:0];
        end
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_docs_reg <= 13'd4096;
            avg_len_reg  <= 24'd256;
            k1_reg       <= 16'd6554;
            b_reg        <= 13'd3072;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_NUM_DOCS: num_docs_reg <= cfg_data[12:0];
                CFG_AVG_LEN:  avg_len_reg  <= cfg_data;
                CFG_K1:       k1_reg       <= cfg_data[15:0];
                CFG_B:        b_reg        <= cfg_data[12:0];
                default:      ;
            endcase
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:   if (clr_cnt_reg == AW'(MAX_DOCS - 1)) state_next = ST_IDLE;
            ST_IDLE:
            begin
                if (accept && req.req_type == REQ_ACC)
                begin
                    state_next = ST_LOGN;
                end
                else if (accept && req.req_type == REQ_READ)
                begin
                    state_next = ST_RD_WAIT;
                end
            end
            ST_RD_WAIT: state_next = ST_IDLE;
            ST_LOGN:    if (log_sts.done) state_next = ST_LOGD;
            ST_LOGD:    if (log_sts.done) state_next = ST_IDF;
            ST_IDF:     state_next = ST_LMUL;
            ST_LMUL:    state_next = ST_LDIV;
            ST_LDIV:    if (div_sts.done) state_next = ST_KMUL0;
            ST_KMUL0:   state_next = ST_KMUL1;
            ST_KMUL1:   state_next = ST_WDIV;
            ST_WDIV:    if (div_sts.done || den_reg == '0) state_next = ST_CMUL;
            ST_CMUL:    state_next = ST_UPD;
            ST_UPD:     state_next = ST_IDLE;
            default:    state_next = ST_IDLE;
        endcase
    end

    // Outputs of the sequencer
    always_comb
    begin
        busy        = (state_reg != ST_IDLE);
        log_start   = 1'b0;
        log_x       = numr;
        div_start   = 1'b0;
        div_num     = DIV_NUM_W'(blen_reg);
        div_den     = DIV_DEN_W'(avg_eff);
        score_we    = 1'b0;
        score_waddr = idx;
        score_wdata = '0;
        score_re    = 1'b0;
        len_we      = 1'b0;
        len_re      = 1'b0;
        case (state_reg)
            ST_CLEAR:
            begin
                score_we    = 1'b1;
                score_waddr = clr_cnt_reg;
            end
            ST_IDLE:
            begin
                len_we   = accept && req.req_type == REQ_WRLEN;
                len_re   = accept && req.req_type == REQ_ACC;
                score_re = accept && (req.req_type == REQ_ACC || req.req_type == REQ_READ);
            end
            ST_RD_WAIT: score_we = 1'b1;
            ST_LOGN:    log_start = !log_sts.busy && !log_sts.done;
            ST_LOGD:
            begin
                log_x     = denr;
                log_start = !log_sts.busy && !log_sts.done;
            end
            ST_LDIV:    div_start = !div_sts.busy && !div_sts.done;
            ST_WDIV:
            begin
                div_num   = {wnum_reg, 28'b0};
                div_den   = den_reg;
                div_start = !div_sts.busy && !div_sts.done && den_reg != '0;
            end
            ST_UPD:
            begin
                score_we    = 1'b1;
                score_wdata = s_sat;
            end
            default:    ;
        endcase
    end

    // State, clear sweep and result strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_CLEAR;
            clr_cnt_reg      <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            result_valid_reg <= (state_reg == ST_RD_WAIT);
            if (state_reg == ST_CLEAR)
            begin
                clr_cnt_reg <= clr_cnt_reg + AW'(1);
            end
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg <= req;
        end
        case (state_reg)
            ST_RD_WAIT:
            begin
                result_reg.doc_id_out <= req_reg.doc_id;
                result_reg.score      <= score_rdata;
            end
            ST_LOGN:
            begin
                if (log_sts.done)
                begin
                    ln_reg <= log_res;
                end
            end
            ST_LOGD:
            begin
                if (log_sts.done)
                begin
                    neg_reg  <= log_res > ln_reg;
                    dmag_reg <= (log_res > ln_reg) ? log_res - ln_reg : ln_reg - log_res;
                end
            end
            ST_IDF:     idf_reg  <= idf_prod[53:34];
            ST_LMUL:    blen_reg <= {29'(b_eff) * 29'(len_rdata), 8'b0};
            ST_LDIV:
            begin
                if (div_sts.done)
                begin
                    norm_reg <= NORM_W'(13'd4096 - b_eff) + div_quot[NORM_W-1:0];
                end
            end
            ST_KMUL0:
            begin
                kprod_lo_reg <= k1_reg * norm_reg[18:0];
                wnum_reg     <= req_reg.term_freq * (17'(k1_reg) + 17'd4096);
            end
            ST_KMUL1:
            begin
                den_reg <= (54'(req_reg.term_freq) << 24) + khi_prod + 54'(kprod_lo_reg);
            end
            ST_WDIV:
            begin
                if (den_reg == '0)
                begin
                    w_reg <= '0;
                end
                else if (div_sts.done)
                begin
                    w_reg <= div_quot[WGT_W-1:0];
                end
            end
            ST_CMUL:    cmag_reg <= cmag_prod[41:16];
            default:    ;
        endcase
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    bsa_log2 u_log2 (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (log_start),
        .x      (log_x),
        .sts    (log_sts),
        .result (log_res)
    );

    bsa_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .sts   (div_sts),
        .quot  (div_quot)
    );

    bsa_ram #(
        .WIDTH (32),
        .DEPTH (MAX_DOCS)
    ) u_score_ram (
        .clk   (clk),
        .we    (score_we),
        .waddr (score_waddr),
        .wdata (score_wdata),
        .re    (score_re),
        .raddr (in_idx),
        .rdata (score_rdata)
    );

    bsa_ram #(
        .WIDTH (16),
        .DEPTH (MAX_DOCS)
    ) u_len_ram (
        .clk   (clk),
        .we    (len_we),
        .waddr (in_idx),
        .wdata (req.doc_len),
        .re    (len_re),
        .raddr (in_idx),
        .rdata (len_rdata)
    );

    // A result strobe follows only the read wait step
    a_result_from_read: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> $past(state_reg == ST_RD_WAIT))
        else $error("result strobe without a read");

    // An accepted read goes straight to the read wait step
    a_read_path: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && req.req_type == REQ_READ) |=> state_reg == ST_RD_WAIT)
        else $error("read request not followed by read wait");

    // Score writes happen only while clearing, reading or updating
    a_score_write: assert property (@(posedge clk) disable iff (!rst_n)
        score_we |-> (state_reg == ST_CLEAR || state_reg == ST_RD_WAIT
                      || state_reg == ST_UPD))
        else $error("unexpected score write");

    // The units are never started while running
    a_unit_start: assert property (@(posedge clk) disable iff (!rst_n)
        !(log_start && log_sts.busy) && !(div_start && div_sts.busy))
        else $error("unit restarted while busy");

endmodule

// ===== dv/bm25_score_accumulator_unit_test.sv =====
`timescale 1ns / 1ps
module bm25_score_accumulator_unit_test;
    import bsa_pkg::*;

    localparam int DOCS = 4096;
    localparam logic [1:0] REQ_BAD = 2'd3;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    bsa_req_t    req;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [23:0] cfg_data;
    logic        result_valid;
    bsa_res_t    result;

    bm25_score_accumulator_unit #(.MAX_DOCS(DOCS)) u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .req          (req),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .result_valid (result_valid),
        .result       (result)
    );

    // Mirror of the block state
    logic [12:0]        n_docs;
    logic [23:0]        avg_len;
    logic [15:0]        k1;
    logic [12:0]        b_norm;
    logic signed [31:0] score_mem [DOCS];
    logic [15:0]        len_mem [DOCS];
    bit                 len_written [DOCS];
    int                 written_ids [$];

    bsa_req_t pending_reqs [$];
    bsa_res_t score_reads [$];
    int       idle_pct;
    int       errors;

    // Clock
    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic longint unsigned log2_fx(input longint unsigned x);
        longint unsigned e;
        longint unsigned m;
        longint unsigned frac;
        e = 0;
        frac = 0;
        if (x == 0) x = 1;
        while (e < 31 && (x >> (e + 1)) != 0) e++;
        m = (x << 30) >> e;
        for (int i = 19; i >= 0; i--)
        begin
            m = (m * m) >> 30;
            if (m >= (64'd2 << 30))
            begin
                m = m >> 1;
                frac = frac | (64'd1 << i);
            end
        end
        return (e << 20) | frac;
    endfunction

    // Add one posting's BM25 contribution to the mirrored score
    task automatic add_posting(input int idx, input longint unsigned tf,
                               input longint unsigned df);
        longint unsigned numr, denr, ln, ld, dmag, idf_mag;
        longint unsigned avg, bb, len, norm, den, w, cmag;
        longint s;
        bit neg;
        numr = (df > n_docs) ? 1 : (2 * longint'(n_docs) - 2 * df + 1);
        denr = 2 * df + 1;
        ln = log2_fx(numr);
        ld = log2_fx(denr);
        neg = ld > ln;
        dmag = neg ? (ld - ln) : (ln - ld);
        idf_mag = (dmag * 64'd744261118 + (64'd1 << 33)) >> 34;
        avg = (avg_len != 0) ? avg_len : 1;
        bb = (b_norm > 4096) ? 4096 : b_norm;
        len = len_mem[idx];
        norm = (4096 - bb) + (bb * len * 256) / avg;
        den = (tf << 24) + longint'(k1) * norm;
        w = 0;
        if (den != 0) w = ((tf * (longint'(k1) + 4096)) << 28) / den;
        cmag = (idf_mag * w + (64'd1 << 15)) >> 16;
        s = longint'(score_mem[idx]);
        if (neg) s = s - longint'(cmag);
        else s = s + longint'(cmag);
        if (s > 64'sd2147483647) s = 64'sd2147483647;
        if (s < -64'sd2147483648) s = -64'sd2147483648;
        score_mem[idx] = s[31:0];
    endtask

    task automatic predict(input bsa_req_t r);
        bsa_res_t x;
        case (r.req_type)
            REQ_WRLEN: len_mem[r.doc_id] = r.doc_len;
            REQ_ACC:   add_posting(r.doc_id, r.term_freq, r.doc_freq);
            REQ_READ:
            begin
                x.doc_id_out = r.doc_id;
                x.score = score_mem[r.doc_id];
                score_mem[r.doc_id] = '0;
                score_reads.push_back(x);
            end
            default: ;
        endcase
    endtask

    // Driver: offer the oldest pending word, hold it until taken
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (start && !busy)
            begin
                predict(req);
                void'(pending_reqs.pop_front());
            end
            if (!(start && busy))
            begin
                if (pending_reqs.size() > 0 && $urandom_range(99) >= idle_pct)
                begin
                    start <= 1'b1;
                    req <= pending_reqs[0];
                end
                else
                    start <= 1'b0;
            end
        end
    end

    // Monitor: check each read word against the oldest expected score
    always @(posedge clk)
    begin
        if (rst_n && result_valid)
        begin
            if (score_reads.size() == 0)
            begin
                $display("%0t: unexpected result doc %0d score %0d", $time,
                         result.doc_id_out, result.score);
                errors++;
            end
            else
            begin
                if (result.doc_id_out !== score_reads[0].doc_id_out)
                begin
                    $display("%0t: doc_id_out expected %0d actual %0d", $time,
                             score_reads[0].doc_id_out, result.doc_id_out);
                    errors++;
                end
                if (result.score !== score_reads[0].score)
                begin
                    $display("%0t: score expected %0d actual %0d", $time,
                             score_reads[0].score, result.score);
                    errors++;
                end
                void'(score_reads.pop_front());
            end
        end
    end

    task automatic write_reg(input logic [1:0] idx, input logic [23:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            CFG_NUM_DOCS: n_docs = val[12:0];
            CFG_AVG_LEN:  avg_len = val;
            CFG_K1:       k1 = val[15:0];
            default:      b_norm = val[12:0];
        endcase
        cfg_valid <= 1'b0;
    endtask

    task automatic set_regs(input logic [23:0] n, input logic [23:0] a,
                            input logic [23:0] k, input logic [23:0] bv);
        write_reg(CFG_NUM_DOCS, n);
        write_reg(CFG_AVG_LEN, a);
        write_reg(CFG_K1, k);
        write_reg(CFG_B, bv);
    endtask

    // Drain all words and let a trailing accumulate finish
    task automatic wait_drained();
        while (pending_reqs.size() != 0 || start || score_reads.size() != 0)
            @(posedge clk);
        repeat (400) @(posedge clk);
    endtask

    function automatic bsa_req_t mk(input logic [1:0] t, input int id,
                                    input int tf, input int df, input int len);
        bsa_req_t r;
        r.req_type = t;
        r.doc_id = id[11:0];
        r.term_freq = tf[15:0];
        r.doc_freq = df[12:0];
        r.doc_len = len[15:0];
        return r;
    endfunction

    task automatic queue_item(input bsa_req_t r);
        if (r.req_type == REQ_WRLEN && !len_written[r.doc_id])
        begin
            len_written[r.doc_id] = 1'b1;
            written_ids.push_back(r.doc_id);
        end
        pending_reqs.push_back(r);
    endtask

    function automatic int rand_df();
        int roll;
        roll = $urandom_range(9);
        if (roll == 0) return $urandom_range(8191);
        if (roll == 1) return 1;
        return $urandom_range(4096, 1);
    endfunction

    // Random mix of requests; postings only hit documents with a length
    task automatic queue_random(input int count);
        int roll;
        int id;
        for (int i = 0; i < count; i++)
        begin
            roll = $urandom_range(99);
            if (roll < 20 || written_ids.size() == 0)
                queue_item(mk(REQ_WRLEN, $urandom, $urandom, $urandom, $urandom));
            else if (roll < 65)
            begin
                id = written_ids[$urandom_range(written_ids.size() - 1)];
                queue_item(mk(REQ_ACC, id, $urandom, rand_df(), $urandom));
            end
            else if (roll < 95)
            begin
                if ($urandom_range(1)) id = written_ids[$urandom_range(written_ids.size() - 1)];
                else id = $urandom;
                queue_item(mk(REQ_READ, id, $urandom, $urandom, $urandom));
            end
            else
                queue_item(mk(REQ_BAD, $urandom, $urandom, $urandom, $urandom));
        end
    endtask

    initial
    begin
        errors = 0;
        idle_pct = 0;
        start = 1'b0;
        req = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        n_docs = 13'd4096;
        avg_len = 24'd256;
        k1 = 16'd6554;
        b_norm = 13'd3072;
        for (int i = 0; i < DOCS; i++)
        begin
            score_mem[i] = '0;
            len_mem[i] = '0;
            len_written[i] = 1'b0;
        end
        rst_n = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: field extremes and special cases at reset settings
        queue_item(mk(REQ_WRLEN, 0, 0, 0, 0));
        queue_item(mk(REQ_WRLEN, 4095, 65535, 8191, 65535));
        queue_item(mk(REQ_ACC, 0, 0, 1, 0));
        queue_item(mk(REQ_ACC, 0, 65535, 1, 0));
        queue_item(mk(REQ_ACC, 4095, 65535, 4096, 65535));
        queue_item(mk(REQ_ACC, 4095, 1, 8191, 0));
        queue_item(mk(REQ_ACC, 4095, 300, 0, 0));
        queue_item(mk(REQ_ACC, 0, 7, 2048, 0));
        queue_item(mk(REQ_READ, 0, 65535, 8191, 65535));
        queue_item(mk(REQ_READ, 4095, 0, 0, 0));
        queue_item(mk(REQ_READ, 4095, 0, 0, 0));
        queue_item(mk(REQ_READ, 100, 0, 0, 0));
        queue_item(mk(REQ_BAD, 4095, 65535, 8191, 65535));
        queue_item(mk(REQ_READ, 0, 0, 0, 0));
        wait_drained();

        // Low extremes: one document, zero average, no k1, no length term
        set_regs(1, 0, 0, 0);
        queue_item(mk(REQ_ACC, 0, 5, 1, 0));
        queue_item(mk(REQ_ACC, 0, 0, 1, 0));
        queue_item(mk(REQ_READ, 0, 0, 0, 0));
        queue_random(100);
        wait_drained();

        // High extremes, b above one, sender mostly idle
        idle_pct = 78;
        set_regs(24'd8191, 24'hFFFFFF, 24'hFFFF, 24'd8191);
        queue_random(150);
        wait_drained();

        // Drive one score into both saturation limits
        idle_pct = 0;
        set_regs(4096, 256, 24'hFFFF, 0);
        queue_item(mk(REQ_WRLEN, 5, 0, 0, 1));
        for (int i = 0; i < 250; i++)
            queue_item(mk(REQ_ACC, 5, 65535, 1, 0));
        queue_item(mk(REQ_READ, 5, 0, 0, 0));
        for (int i = 0; i < 250; i++)
            queue_item(mk(REQ_ACC, 5, 65535, 4096, 0));
        queue_item(mk(REQ_READ, 5, 0, 0, 0));
        wait_drained();

        // Random settings
        for (int p = 0; p < 3; p++)
        begin
            idle_pct = (p == 1) ? 19 : 0;
            set_regs(24'($urandom_range(8191)), 24'($urandom), 24'($urandom),
                     24'($urandom_range(8191)));
            queue_random(100);
            wait_drained();
        end

        if (errors == 0)
            $display("bm25_score_accumulator_unit_test OK");
        else
            $display("bm25_score_accumulator_unit_test NOT OK");
        $finish;
    end

    // Watchdog
    initial
    begin
        #20000000;
        $display("bm25_score_accumulator_unit_test NOT OK");
        $finish;
    end

endmodule
